/* rtl/yck_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// yck_pkg
// Shared types and constants for the YUV 4:2:0 chroma-key compositor.
// ----------------------------------------------------------------------------
package yck_pkg;

    localparam int BLOCK_W   = 48;   // y00,y01,y10,y11,u,v from bit 0 upward
    localparam int SAMPLE_W  = 8;
    localparam int KEY_DEPTH = 256;  // entries per key table
    localparam int KEY_AW    = $clog2(KEY_DEPTH);

    // byte positions inside a block
    localparam int BYTE_Y00 = 0;
    localparam int BYTE_U   = 4;
    localparam int BYTE_V   = 5;

    localparam logic [SAMPLE_W-1:0] NEUTRAL_CHROMA = 8'h80;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BLOCK = 1'b1;

    // key table select codes
    localparam logic [1:0] TSEL_Y = 2'd0;
    localparam logic [1:0] TSEL_U = 2'd1;
    localparam logic [1:0] TSEL_V = 2'd2;

    typedef enum logic [1:0] {
        SRC_LIVE  = 2'd0,
        SRC_BACK  = 2'd1,
        SRC_WATER = 2'd2
    } t_src;

endpackage : yck_pkg
`default_nettype wire

/* rtl/yck_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// yck_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module yck_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : yck_ram
`default_nettype wire

/* rtl/yuv420_chroma_key_compositor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_chroma_key_compositor
// Chroma-key compositor for 4:2:0 blocks with optional watermark overlay.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_cmd, i_*_block, i_table_*
//  out     | output    | o_out_valid / i_out_ready  | o_out_block, o_source_used
//  cfg     | input     | i_cfg_wr_en (no wait)      | i_cfg_wr_data
//
//  One request per cycle is accepted when no stall or clear pass holds the input;
//  a block request gives its result after the key table read, then the output register.
//  Table write requests produce no result.
//  After reset a clearing pass zeroes the three key tables, one entry of each
//  table per cycle; o_in_ready is low during it.
//  A stalled output holds the request in the read stage; input ready then
//  follows i_out_ready.
// ----------------------------------------------------------------------------
module yuv420_chroma_key_compositor
    import yck_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    // input request
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_cmd,
    input  wire logic [BLOCK_W-1:0] i_live_block,
    input  wire logic [BLOCK_W-1:0] i_back_block,
    input  wire logic [BLOCK_W-1:0] i_water_block,
    input  wire logic [1:0]         i_table_select,
    input  wire logic [KEY_AW-1:0]  i_table_index,
    input  wire logic               i_table_bit,
    // result
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [BLOCK_W-1:0]      o_out_block,
    output logic [1:0]              o_source_used
);

    // ---------------- control registers ----------------
    logic              r_wm_en;
    logic              r_clr_busy;
    logic [KEY_AW-1:0] r_clr_addr;
    logic              r_s1_valid;
    logic              r_out_valid;

    // ---------------- read stage payload ----------------
    logic               r_s1_wm;
    logic [BLOCK_W-1:0] r_s1_live;
    logic [BLOCK_W-1:0] r_s1_back;
    logic [BLOCK_W-1:0] r_s1_water;

    // ---------------- output payload ----------------
    logic [BLOCK_W-1:0] r_out_block;
    t_src               r_out_src;
    logic [BLOCK_W-1:0] n_out_block;
    t_src               n_out_src;

    logic in_acc;
    logic s1_adv;
    logic blk_acc;
    logic wr_acc;
    logic wm_hit;

    // key table ports, one RAM per table
    logic [2:0]        tbl_we;
    logic [KEY_AW-1:0] tbl_waddr;
    logic              tbl_wdata;
    logic [2:0]        tbl_rdata;
    logic [KEY_AW-1:0] tbl_raddr [3];

    // read stage can move when the output register is free or being drained
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;
    assign blk_acc    = in_acc && (i_cmd == CMD_BLOCK);
    assign wr_acc     = in_acc && (i_cmd == CMD_WRITE);

    // watermark wins only when both of its chroma bytes are off neutral
    assign wm_hit = r_wm_en
                 && (i_water_block[SAMPLE_W*BYTE_U +: SAMPLE_W] != NEUTRAL_CHROMA)
                 && (i_water_block[SAMPLE_W*BYTE_V +: SAMPLE_W] != NEUTRAL_CHROMA);

    // table write side: clearing sweep first, then write requests
    always_comb begin
        tbl_we    = 3'b000;
        tbl_waddr = i_table_index;
        tbl_wdata = i_table_bit;
        if (r_clr_busy) begin
            tbl_we    = 3'b111;
            tbl_waddr = r_clr_addr;
            tbl_wdata = 1'b0;
        end else if (wr_acc) begin
            unique case (i_table_select)
                TSEL_Y:  tbl_we = 3'b001;
                TSEL_U:  tbl_we = 3'b010;
                TSEL_V:  tbl_we = 3'b100;
                default: tbl_we = 3'b000;   // unused select, dropped
            endcase
        end
    end

    assign tbl_raddr[0] = i_live_block[SAMPLE_W*BYTE_Y00 +: SAMPLE_W];
    assign tbl_raddr[1] = i_live_block[SAMPLE_W*BYTE_U   +: SAMPLE_W];
    assign tbl_raddr[2] = i_live_block[SAMPLE_W*BYTE_V   +: SAMPLE_W];

    // A write lands at its accept edge; a later block request reads at its own
    // accept edge, so ordering is preserved without forwarding.
    for (genvar g = 0; g < 3; g++) begin : g_tbl
        yck_ram #(
            .WIDTH (1),
            .DEPTH (KEY_DEPTH)
        ) u_key_ram (
            .i_clk   (i_clk),
            .i_we    (tbl_we[g]),
            .i_waddr (tbl_waddr),
            .i_wdata (tbl_wdata),
            .i_re    (blk_acc),
            .i_raddr (tbl_raddr[g]),
            .o_rdata (tbl_rdata[g])
        );
    end

    // key decision on the registered lookups
    always_comb begin
        if (r_s1_wm) begin
            n_out_block = r_s1_water;
            n_out_src   = SRC_WATER;
        end else if (&tbl_rdata) begin
            n_out_block = r_s1_back;
            n_out_src   = SRC_BACK;
        end else begin
            n_out_block = r_s1_live;
            n_out_src   = SRC_LIVE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm_en     <= 1'b1;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wm_en <= i_cfg_wr_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == KEY_AW'(KEY_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (!r_s1_valid || s1_adv) begin
                r_s1_valid <= blk_acc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (blk_acc) begin
            r_s1_wm    <= wm_hit;
            r_s1_live  <= i_live_block;
            r_s1_back  <= i_back_block;
            r_s1_water <= i_water_block;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_block <= n_out_block;
            r_out_src   <= n_out_src;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_block   = r_out_block;
    assign o_source_used = r_out_src;

endmodule : yuv420_chroma_key_compositor
`default_nettype wire

/* rtl/yck_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// yck_chk
// Port-level checker for the chroma-key compositor, bound to the top level.
// ----------------------------------------------------------------------------
module yck_chk
    import yck_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               i_cmd,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [BLOCK_W-1:0] o_out_block,
    input wire logic [1:0]         o_source_used
);

    // no request is taken as reset is released, while the tables are being cleared
    a_clear_blocks: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("request accepted during table clear");

    // a block request goes through read and output registers when output is free
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_cmd == CMD_BLOCK && !o_out_valid)
        |=> ##1 o_out_valid)
        else $error("block request result missing");

    // watermark output only when both watermark chroma bytes are off neutral
    a_water_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_source_used == SRC_WATER)
        |-> (o_out_block[SAMPLE_W*BYTE_U +: SAMPLE_W] != NEUTRAL_CHROMA)
         && (o_out_block[SAMPLE_W*BYTE_V +: SAMPLE_W] != NEUTRAL_CHROMA))
        else $error("watermark chosen with neutral chroma");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> o_out_valid && $stable(o_out_block) && $stable(o_source_used))
        else $error("stalled result changed");

endmodule : yck_chk

bind yuv420_chroma_key_compositor yck_chk u_yck_chk (.*);
`default_nettype wire
